>>> sv/crc16_frame_receiver_unit_macros.svh
// assertion macros for the crc16 frame receiver
// no dependencies; define SYNTH to drop the checks from a build
`ifndef CRC16_FRAME_RECEIVER_UNIT_MACROS_SVH
`define CRC16_FRAME_RECEIVER_UNIT_MACROS_SVH
`ifndef SYNTH
// condition that must hold at every clock edge out of reset
`define FRC_ASSERT(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("frc assertion failed");
// antecedent implies consequent on the next edge
`define FRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frc assertion failed");
`else
`define FRC_ASSERT(lbl, clk, rst_n, cond)
`define FRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/frc_pkg.sv
// shared types, constants and the crc byte update for the frame receiver
// no dependencies
package frc_pkg;

    localparam int CNT_W = 17;

    localparam logic [7:0]       SOF_FIRST       = 8'hAA;
    localparam logic [7:0]       SOF_SECOND      = 8'h55;
    localparam logic [15:0]      CRC_INIT        = 16'hFFFF;
    localparam logic [15:0]      CRC_POLY        = 16'hA001;
    localparam logic [CNT_W-1:0] MAX_FRAME_RESET = 17'd256;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_SOF2 = 3'd1,
        PH_LEN  = 3'd2,
        PH_BODY = 3'd3,
        PH_FCS  = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_PAYLOAD = 2'd1,
        EV_FRAME   = 2'd2
    } t_event;

    typedef enum logic [2:0] {
        ERR_OK       = 3'd0,
        ERR_FORMAT   = 3'd1,
        ERR_LENGTH   = 3'd2,
        ERR_TYPE     = 3'd3,
        ERR_DEVICE   = 3'd4,
        ERR_REGISTER = 3'd5,
        ERR_CRC      = 3'd6
    } t_err;

    typedef struct packed {
        t_event      event_res;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic [7:0]  msg_type;
        logic [7:0]  device_address;
        logic [15:0] register_address;
        logic [15:0] data_length;
        t_err        fault_code;
    } t_result;

    // reflected crc-16, one byte folded in over eight bit steps
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> sv/crc16_frame_receiver_unit.sv
// Framed byte receiver: hunts for AA 55, parses length and header, passes each
// payload byte on and closes every frame with a header report and error code
// (crc-16, reflected 0xA001, initial 0xFFFF). Every accepted byte gives exactly one
// result request; a byte is taken every cycle while results are drained. A byte
// accepted into the input register is parsed from it once the result register has
// room, and its result is then loaded into the result register and presented from
// there. The rate is set by the parser, which folds a whole byte into its state
// and crc in each step. The user must write max_frame_bytes on the cfg channel
// only while the block is idle; the block itself does not enforce this.
// depends on frc_pkg, frc_in_stage, frc_frame_core, frc_out_stage and the macros header
`include "crc16_frame_receiver_unit_macros.svh"
module crc16_frame_receiver_unit
    import frc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_event_res,
    output logic [7:0]  o_payload_byte,
    output logic [15:0] o_payload_index,
    output logic [7:0]  o_msg_type,
    output logic [7:0]  o_device_address,
    output logic [15:0] o_register_address,
    output logic [15:0] o_data_length,
    output logic [2:0]  o_fault_code,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [16:0] i_max_frame_bytes
);

    logic [CNT_W-1:0] r_max_frame_bytes;
    logic             w_stage_valid;
    logic [7:0]       w_stage_byte;
    logic             w_out_space;
    logic             w_advance;
    t_result          w_result;
    t_result          w_out_result;

    // configuration register, always writable
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_frame_bytes <= MAX_FRAME_RESET;
        end else if (i_cfg_valid) begin
            r_max_frame_bytes <= i_max_frame_bytes;
        end
    end

    // held byte moves when the result register has room
    assign w_advance = w_stage_valid && w_out_space;

    frc_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_rx_byte  (i_rx_byte),
        .i_advance  (w_advance),
        .o_valid    (w_stage_valid),
        .o_byte     (w_stage_byte)
    );

    frc_frame_core u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_step            (w_advance),
        .i_byte            (w_stage_byte),
        .i_max_frame_bytes (r_max_frame_bytes),
        .o_result          (w_result)
    );

    frc_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_advance),
        .i_result (w_result),
        .o_space  (w_out_space),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (w_out_result)
    );

    // result fields
    assign o_event_res        = w_out_result.event_res;
    assign o_payload_byte     = w_out_result.payload_byte;
    assign o_payload_index    = w_out_result.payload_index;
    assign o_msg_type         = w_out_result.msg_type;
    assign o_device_address   = w_out_result.device_address;
    assign o_register_address = w_out_result.register_address;
    assign o_data_length      = w_out_result.data_length;
    assign o_fault_code       = w_out_result.fault_code;

    // checks
    `FRC_ASSERT(a_err_flag, i_clk, i_rst_n, !(o_out_valid && o_event_res == EV_FRAME) || (o_msg_type[7] == (o_fault_code != ERR_OK)))
    `FRC_ASSERT(a_payload_clear, i_clk, i_rst_n, !(o_out_valid && o_event_res != EV_PAYLOAD) || (o_payload_byte == 8'h00 && o_payload_index == 16'h0000))
    `FRC_ASSERT(a_stall_blocks, i_clk, i_rst_n, !(w_stage_valid && !w_advance) || !o_in_ready)
    `FRC_ASSERT_NEXT(a_step_fills, i_clk, i_rst_n, w_advance, o_out_valid)
    `FRC_ASSERT_NEXT(a_cfg_held, i_clk, i_rst_n, i_cfg_valid, r_max_frame_bytes == $past(i_max_frame_bytes))

endmodule

>>> sv/frc_in_stage.sv
// input register for received bytes
// depends on frc_pkg
module frc_in_stage
    import frc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_advance,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    // free when empty or when the held request moves on this cycle
    assign o_in_ready = !r_valid || i_advance;

    // hold one request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_byte <= i_rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

>>> sv/frc_frame_core.sv
// frame parser state, crc accumulation, header checks and result forming
// depends on frc_pkg
module frc_frame_core
    import frc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    input  logic [CNT_W-1:0] i_max_frame_bytes,
    output t_result          o_result
);

    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_count, n_count;
    logic [15:0]      r_length, n_length;
    logic [7:0]       r_type, n_type;
    logic [7:0]       r_device, n_device;
    logic [15:0]      r_register, n_register;
    logic [15:0]      r_data_len, n_data_len;
    logic [15:0]      r_crc, n_crc;
    logic [7:0]       r_fcs_low, n_fcs_low;

    logic             w_too_long;
    logic             w_fcs_start;
    t_phase           w_phase;
    logic [CNT_W-1:0] w_len_ext;
    logic [15:0]      w_crc_next;
    logic             w_last_fcs;
    t_err             w_judge;
    logic [CNT_W-1:0] w_index;

    // frame overrun and body-to-fcs switch
    assign w_len_ext   = {1'b0, r_length};
    assign w_too_long  = (r_phase != PH_HUNT) && (r_count >= i_max_frame_bytes);
    assign w_fcs_start = (r_phase == PH_BODY) && (r_count >= w_len_ext + 17'd4);
    assign w_phase     = w_fcs_start ? PH_FCS : r_phase;
    assign w_crc_next  = crc_byte(r_crc, i_byte);
    assign w_last_fcs  = !(r_count < w_len_ext + 17'd5);
    assign w_index     = r_count - 17'd10;

    // header and crc checks, the later failing check wins, bad length overrides all
    always_comb begin
        w_judge = ERR_OK;
        if ((r_type & 8'h70) != 8'h00) begin
            w_judge = ERR_TYPE;
        end
        if (r_device == 8'h00 || r_device == 8'hFF) begin
            w_judge = ERR_DEVICE;
        end
        if (r_register == 16'h0000 || r_register == 16'hFFFF) begin
            w_judge = ERR_REGISTER;
        end
        if ({i_byte, r_fcs_low} != r_crc) begin
            w_judge = ERR_CRC;
        end
        if (r_length < 16'd6 || w_len_ext != {1'b0, r_data_len} + 17'd6) begin
            w_judge = ERR_FORMAT;
        end
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (w_too_long) begin
            n_phase = PH_HUNT;
        end else begin
            case (w_phase)
                PH_HUNT: begin
                    if (i_byte == SOF_FIRST) n_phase = PH_SOF2;
                end
                PH_SOF2: begin
                    n_phase = (i_byte == SOF_SECOND) ? PH_LEN : PH_HUNT;
                end
                PH_LEN: begin
                    if (r_count != 17'd2) n_phase = PH_BODY;
                end
                PH_BODY: begin
                    n_phase = PH_BODY;
                end
                PH_FCS: begin
                    n_phase = w_last_fcs ? PH_HUNT : PH_FCS;
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    // frame fields and result
    always_comb begin
        n_count    = r_count;
        n_length   = r_length;
        n_type     = r_type;
        n_device   = r_device;
        n_register = r_register;
        n_data_len = r_data_len;
        n_crc      = r_crc;
        n_fcs_low  = r_fcs_low;
        o_result   = '0;
        if (w_too_long) begin
            o_result.event_res        = EV_FRAME;
            o_result.msg_type         = {1'b1, r_type[6:0]};
            o_result.device_address   = r_device;
            o_result.register_address = r_register;
            o_result.data_length      = r_data_len;
            o_result.fault_code       = ERR_LENGTH;
        end else begin
            case (w_phase)
                PH_HUNT: begin
                    if (i_byte == SOF_FIRST) begin
                        n_count    = 17'd1;
                        n_length   = '0;
                        n_type     = '0;
                        n_device   = '0;
                        n_register = '0;
                        n_data_len = '0;
                        n_crc      = CRC_INIT;
                        n_fcs_low  = '0;
                    end
                end
                PH_SOF2: begin
                    if (i_byte == SOF_SECOND) begin
                        n_count = 17'd2;
                    end else begin
                        o_result.event_res        = EV_FRAME;
                        o_result.msg_type         = {1'b1, r_type[6:0]};
                        o_result.device_address   = r_device;
                        o_result.register_address = r_register;
                        o_result.data_length      = r_data_len;
                        o_result.fault_code       = ERR_FORMAT;
                    end
                end
                PH_LEN: begin
                    n_crc   = w_crc_next;
                    n_count = r_count + 17'd1;
                    if (r_count == 17'd2) n_length[7:0]  = i_byte;
                    else                  n_length[15:8] = i_byte;
                end
                PH_BODY: begin
                    n_crc   = w_crc_next;
                    n_count = r_count + 17'd1;
                    if (r_count == 17'd4)      n_type             = i_byte;
                    else if (r_count == 17'd5) n_device           = i_byte;
                    else if (r_count == 17'd6) n_register[7:0]    = i_byte;
                    else if (r_count == 17'd7) n_register[15:8]   = i_byte;
                    else if (r_count == 17'd8) n_data_len[7:0]    = i_byte;
                    else if (r_count == 17'd9) n_data_len[15:8]   = i_byte;
                    else begin
                        o_result.event_res     = EV_PAYLOAD;
                        o_result.payload_byte  = i_byte;
                        o_result.payload_index = w_index[15:0];
                    end
                end
                PH_FCS: begin
                    n_count = r_count + 17'd1;
                    if (!w_last_fcs) begin
                        n_fcs_low = i_byte;
                    end else begin
                        o_result.event_res        = EV_FRAME;
                        o_result.msg_type         = {(w_judge != ERR_OK), r_type[6:0]};
                        o_result.device_address   = r_device;
                        o_result.register_address = r_register;
                        o_result.data_length      = r_data_len;
                        o_result.fault_code       = w_judge;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // state update on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HUNT;
            r_count    <= '0;
            r_length   <= '0;
            r_type     <= '0;
            r_device   <= '0;
            r_register <= '0;
            r_data_len <= '0;
            r_crc      <= CRC_INIT;
            r_fcs_low  <= '0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_count    <= n_count;
            r_length   <= n_length;
            r_type     <= n_type;
            r_device   <= n_device;
            r_register <= n_register;
            r_data_len <= n_data_len;
            r_crc      <= n_crc;
            r_fcs_low  <= n_fcs_low;
        end
    end

endmodule

>>> sv/frc_out_stage.sv
// result register towards the consumer
// depends on frc_pkg
module frc_out_stage
    import frc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    output logic    o_space,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    // room for a new result when empty or being taken now
    assign o_space = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_load;
        end
        if (o_space && i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
